// ===== sv/ckut_pkg.sv =====
// Package for the coalescing keyed update table: field widths, op codes,
// sequencer states and the slot and payload record types.
// No dependencies; every other file of the block depends on it.
package ckut_pkg;

   localparam int DATA_W        = 32;
   localparam int OP_W          = 2;
   localparam int DEFAULT_SLOTS = 24;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_RESYNC = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] stamp;
   } slot_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] key_tag;
      logic [DATA_W-1:0] value_word;
      logic [DATA_W-1:0] cursor_in;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] key_out;
      logic [DATA_W-1:0] value_out;
      logic [DATA_W-1:0] cursor_out;
      logic [DATA_W-1:0] head_seq;
   } rsp_type;

endpackage

// ===== sv/ckut_req_if.sv =====
// Request channel of the coalescing keyed update table: valid/ready plus the
// op, key, value and cursor payload. Depends on ckut_pkg for widths.
interface ckut_req_if;
   logic                        valid;
   logic                        ready;
   logic [ckut_pkg::OP_W-1:0]   op;
   logic [ckut_pkg::DATA_W-1:0] key_tag;
   logic [ckut_pkg::DATA_W-1:0] value_word;
   logic [ckut_pkg::DATA_W-1:0] cursor_in;

   modport source (output valid, op, key_tag, value_word, cursor_in, input ready);
   modport sink   (input valid, op, key_tag, value_word, cursor_in, output ready);
endinterface

// ===== sv/ckut_rsp_if.sv =====
// Response channel of the coalescing keyed update table: valid/ready plus the
// hit flag, popped entry, cursor and head sequence. Depends on ckut_pkg.
interface ckut_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [ckut_pkg::DATA_W-1:0] key_out;
   logic [ckut_pkg::DATA_W-1:0] value_out;
   logic [ckut_pkg::DATA_W-1:0] cursor_out;
   logic [ckut_pkg::DATA_W-1:0] head_seq;

   modport source (output valid, hit, key_out, value_out, cursor_out, head_seq,
                   input ready);
   modport sink   (input valid, hit, key_out, value_out, cursor_out, head_seq,
                   output ready);
endinterface

// ===== sv/coalescing_keyed_update_table.sv =====
// Top level of the coalescing keyed update table.
// Depends on ckut_pkg, ckut_req_if and ckut_rsp_if.
//
// The table holds SLOTS key/value slots in one synchronous memory, each slot
// stamped from a 32-bit global write sequence; a stamp of zero marks a free
// slot, and one valid bit per slot (cleared by reset) makes a never-written
// slot read as free. A push overwrites the live slot with the same key, else
// fills the lowest free slot, else evicts the oldest slot and raises the
// eviction marker; the slot then takes the next sequence number. A pop returns
// the slot with the smallest stamp above the cursor. A resync lifts a cursor
// below the eviction marker up to it. Push and pop walk the memory one slot
// per cycle through its single read port (accept, read every slot, let the
// last read land, commit); resync and the unused op go from accept straight
// to commit. One request is in flight at a time; the response sits in an
// output register, so the next request beat is taken while the previous
// response still waits.
module coalescing_keyed_update_table #(
   parameter int SLOTS = ckut_pkg::DEFAULT_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   ckut_req_if.sink    req_chan,
   ckut_rsp_if.source  rsp_chan
);
   import ckut_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // sequencer
   state_type state_ff, state_in;
   logic      req_ready;
   logic      scan_rd;
   logic      commit_go;
   logic      commit_push;
   logic      rsp_free;
   logic      req_accept;

   // latched request
   req_type req_ff, req_in;

   // scan read pipeline
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_pend_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_valid_ff;
   slot_type         rd_slot_ff;

   // scan accumulators
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic              empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]  empty_idx_ff, empty_idx_in;
   logic              cand_found_ff, cand_found_in;
   logic [IDX_W-1:0]  cand_idx_ff, cand_idx_in;
   logic [DATA_W-1:0] cand_stamp_ff, cand_stamp_in;
   logic [DATA_W-1:0] cand_key_ff, cand_key_in;
   logic [DATA_W-1:0] cand_value_ff, cand_value_in;

   // table state
   slot_type          slot_mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   logic [DATA_W-1:0] write_seq_ff, write_seq_in;
   logic [DATA_W-1:0] mark_ff, mark_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // commit datapath
   logic [IDX_W-1:0]  dst_idx;
   logic [DATA_W-1:0] seq_next;
   logic              evict;
   logic [DATA_W-1:0] stamp_eff;
   logic              live;
   logic              smaller;
   logic              is_push;

   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept  = req_chan.valid && req_ready;
   assign is_push     = (req_ff.op == OP_PUSH);
   assign commit_push = commit_go && is_push;

   //--------------------------------------------------------------------------
   // Sequencer: next state
   //--------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // only push and pop need the slot walk
               if (req_chan.op == OP_PUSH || req_chan.op == OP_POP) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   //--------------------------------------------------------------------------
   // Sequencer: outputs
   //--------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      scan_rd   = 1'b0;
      commit_go = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_rd   = 1'b1;
         ST_FINISH: ;
         ST_COMMIT: commit_go = rsp_free;   // hold until the output register frees
         default:   ;
      endcase
   end

   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   //--------------------------------------------------------------------------
   // Request latch and scan address
   //--------------------------------------------------------------------------
   always_comb begin
      req_in = req_ff;
      if (req_accept) begin
         req_in.op         = req_chan.op;
         req_in.key_tag    = req_chan.key_tag;
         req_in.value_word = req_chan.value_word;
         req_in.cursor_in  = req_chan.cursor_in;
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (req_accept) begin
         scan_idx_in = '0;
      end else if (scan_rd && scan_idx_ff != LAST_IDX) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= scan_rd;
      end
   end

   //--------------------------------------------------------------------------
   // Slot memory: one read port for the walk, one write port for the commit.
   // Accesses never overlap since the commit follows the walk's last read.
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (scan_rd) begin
         rd_slot_ff  <= slot_mem[scan_idx_ff];
         rd_valid_ff <= valid_ff[scan_idx_ff];
      end
      if (commit_push) begin
         slot_mem[dst_idx] <= '{key: req_ff.key_tag, value: req_ff.value_word,
                                stamp: seq_next};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (commit_push) begin
         valid_ff[dst_idx] <= 1'b1;
      end
   end

   //--------------------------------------------------------------------------
   // Walk: fold each landed slot into the match / free / oldest / best trackers.
   // A never-written slot reads as stamp zero, i.e. free.
   //--------------------------------------------------------------------------
   assign stamp_eff = rd_valid_ff ? rd_slot_ff.stamp : '0;
   assign live      = (stamp_eff != '0);
   assign smaller   = !cand_found_ff || (stamp_eff < cand_stamp_ff);

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      cand_found_in  = cand_found_ff;
      cand_idx_in    = cand_idx_ff;
      cand_stamp_in  = cand_stamp_ff;
      cand_key_in    = cand_key_ff;
      cand_value_in  = cand_value_ff;
      if (req_accept) begin
         match_found_in = 1'b0;
         empty_found_in = 1'b0;
         cand_found_in  = 1'b0;
      end else if (rd_pend_ff) begin
         if (is_push) begin
            // once the key matches, the rest of the walk is ignored
            if (!match_found_ff) begin
               if (live && rd_slot_ff.key == req_ff.key_tag) begin
                  match_found_in = 1'b1;
                  match_idx_in   = rd_idx_ff;
               end else begin
                  if (!live && !empty_found_ff) begin
                     empty_found_in = 1'b1;
                     empty_idx_in   = rd_idx_ff;
                  end
                  if (live && smaller) begin
                     cand_found_in = 1'b1;
                     cand_idx_in   = rd_idx_ff;
                     cand_stamp_in = stamp_eff;
                  end
               end
            end
         end else if (stamp_eff > req_ff.cursor_in && smaller) begin
            cand_found_in = 1'b1;
            cand_idx_in   = rd_idx_ff;
            cand_stamp_in = stamp_eff;
            cand_key_in   = rd_slot_ff.key;
            cand_value_in = rd_slot_ff.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
         cand_found_ff  <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         empty_found_ff <= empty_found_in;
         cand_found_ff  <= cand_found_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff  <= match_idx_in;
      empty_idx_ff  <= empty_idx_in;
      cand_idx_ff   <= cand_idx_in;
      cand_stamp_ff <= cand_stamp_in;
      cand_key_ff   <= cand_key_in;
      cand_value_ff <= cand_value_in;
   end

   //--------------------------------------------------------------------------
   // Commit: pick the destination slot, advance the sequence, raise the marker.
   //--------------------------------------------------------------------------
   assign seq_next = write_seq_ff + 1'b1;
   assign evict    = !match_found_ff && !empty_found_ff;

   always_comb begin
      priority if (match_found_ff) begin
         dst_idx = match_idx_ff;
      end else if (empty_found_ff) begin
         dst_idx = empty_idx_ff;
      end else begin
         dst_idx = cand_idx_ff;
      end
   end

   always_comb begin
      write_seq_in = write_seq_ff;
      mark_in      = mark_ff;
      if (commit_push) begin
         write_seq_in = seq_next;
         if (evict && cand_stamp_ff > mark_ff) mark_in = cand_stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_seq_ff <= '0;
         mark_ff      <= '0;
      end else begin
         write_seq_ff <= write_seq_in;
         mark_ff      <= mark_in;
      end
   end

   //--------------------------------------------------------------------------
   // Response register: load on commit, drop on the rsp beat.
   //--------------------------------------------------------------------------
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      if (commit_go) begin
         rsp_data_in.hit        = 1'b0;
         rsp_data_in.key_out    = '0;
         rsp_data_in.value_out  = '0;
         rsp_data_in.cursor_out = req_ff.cursor_in;
         rsp_data_in.head_seq   = write_seq_ff;
         unique case (op_type'(req_ff.op))
            OP_PUSH: begin
               rsp_data_in.head_seq = seq_next;
            end
            OP_POP: begin
               if (cand_found_ff) begin
                  rsp_data_in.hit        = 1'b1;
                  rsp_data_in.key_out    = cand_key_ff;
                  rsp_data_in.value_out  = cand_value_ff;
                  rsp_data_in.cursor_out = cand_stamp_ff;
               end
            end
            OP_RESYNC: begin
               if (req_ff.cursor_in < mark_ff) begin
                  rsp_data_in.hit        = 1'b1;
                  rsp_data_in.cursor_out = mark_ff;
               end
            end
            default: ;   // unused op: no change, answer as a pop that missed
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_data_ff.hit;
   assign rsp_chan.key_out    = rsp_data_ff.key_out;
   assign rsp_chan.value_out  = rsp_data_ff.value_out;
   assign rsp_chan.cursor_out = rsp_data_ff.cursor_out;
   assign rsp_chan.head_seq   = rsp_data_ff.head_seq;

   //--------------------------------------------------------------------------
   // Assertions
   //--------------------------------------------------------------------------
   // The write sequence moves only on a push commit.
   a_seq_only_on_push : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(write_seq_ff)) |-> $past(commit_push))
      else $error("write sequence changed without a push commit");

   // The eviction marker never falls.
   a_mark_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (mark_ff >= $past(mark_ff)))
      else $error("eviction marker decreased");

   // An accepted request leaves idle for the walk or straight for commit.
   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN || state_ff == ST_COMMIT))
      else $error("request beat did not start the sequencer");

   // A commit never overwrites a response that is still waiting.
   a_no_rsp_overrun : assert property (@(posedge clock) disable iff (reset)
      commit_go |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response register overrun");

endmodule
